/* hw/rtl/ipmac_pkg.sv */
// ----------------------------------------------------------------------------
// ipmac_pkg
// Shared widths and codes for the IP-to-MAC address cache.
// ----------------------------------------------------------------------------
package ipmac_pkg;

    localparam int unsigned IP_W  = 32;
    localparam int unsigned MAC_W = 48;

    typedef enum logic {
        MODE_LOOKUP = 1'b0,
        MODE_SAVE   = 1'b1
    } t_mode;

endpackage

/* hw/rtl/ipmac_if.sv */
// ----------------------------------------------------------------------------
// ipmac_if
// Request and response channels of the IP-to-MAC address cache.
// ----------------------------------------------------------------------------
interface ipmac_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [ipmac_pkg::IP_W-1:0]   ip_addr;
    logic [ipmac_pkg::MAC_W-1:0]  mac_addr;

    modport source (output valid, output mode, output ip_addr, output mac_addr,
                    input ready);
    modport sink   (input valid, input mode, input ip_addr, input mac_addr,
                    output ready);
endinterface

interface ipmac_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [ipmac_pkg::MAC_W-1:0]  mac_out;

    modport source (output valid, output hit, output mac_out, input ready);
    modport sink   (input valid, input hit, input mac_out, output ready);
endinterface

/* hw/rtl/ipmac_ram.sv */
// ----------------------------------------------------------------------------
// ipmac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipmac_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ip_to_mac_cache.sv */
// Response path: a request passes the input register, then the result register;
// the result register holds while a pending response is not taken.
// Throughput: one request per cycle unless the response stalls; the compare
// against every key register and the MAC RAM read both complete within one stage each.
// Reset clears entry valid bits, the replacement pointer and pipeline valids;
// in one cycle; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ip_to_mac_cache
// Fully associative IPv4-to-MAC table with round-robin (oldest-first)
// replacement. Keys and valid bits sit in flops; MACs live in a RAM.
// ----------------------------------------------------------------------------
module ip_to_mac_cache #(
    parameter int unsigned TABLE_ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipmac_req_if.sink   i_req,
    ipmac_rsp_if.source o_rsp
);

    localparam int unsigned PTR_W = $clog2(TABLE_ENTRIES);

    // stage 1: input register
    logic                          r_v1;
    logic                          r_mode;
    logic [ipmac_pkg::IP_W-1:0]    r_ip;
    logic [ipmac_pkg::MAC_W-1:0]   r_mac;

    // stage 2: result register (MAC data comes from the RAM read register)
    logic                          r_v2;
    logic                          r_hit;
    logic                          r_lookup_hit;

    // table
    logic [ipmac_pkg::IP_W-1:0]    r_key [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]      r_entry_valid;
    logic [PTR_W-1:0]              r_ptr;
    logic [PTR_W-1:0]              n_ptr;

    logic [TABLE_ENTRIES-1:0]      match_vec;
    logic [PTR_W-1:0]              hit_idx;
    logic                          any_hit;
    logic                          adv;
    logic                          do_save;
    logic                          do_read;
    logic [ipmac_pkg::MAC_W-1:0]   ram_rdata;

    assign adv         = !r_v2 || o_rsp.ready;
    assign i_req.ready = !r_v1 || adv;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match_vec[i] = r_entry_valid[i] && (r_key[i] == r_ip);
        end
    end

    // lowest matching slot wins
    always_comb begin
        hit_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                hit_idx = PTR_W'(i);
            end
        end
    end

    assign any_hit = |match_vec;
    assign do_save = r_v1 && adv && (r_mode == ipmac_pkg::MODE_SAVE) && !any_hit;
    assign do_read = r_v1 && adv && (r_mode == ipmac_pkg::MODE_LOOKUP) && any_hit;
    assign n_ptr   = (r_ptr == PTR_W'(TABLE_ENTRIES - 1)) ? '0 : r_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_entry_valid <= '0;
            r_ptr         <= '0;
        end else begin
            if (i_req.ready) begin
                r_v1 <= i_req.valid;
            end
            if (adv) begin
                r_v2 <= r_v1;
            end
            if (do_save) begin
                r_entry_valid[r_ptr] <= 1'b1;
                r_ptr                <= n_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_mode <= i_req.mode;
            r_ip   <= i_req.ip_addr;
            r_mac  <= i_req.mac_addr;
        end
        if (adv) begin
            r_hit        <= any_hit;
            r_lookup_hit <= (r_mode == ipmac_pkg::MODE_LOOKUP) && any_hit;
        end
        if (do_save) begin
            r_key[r_ptr] <= r_ip;
        end
    end

    ipmac_ram #(
        .WIDTH (ipmac_pkg::MAC_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_mac_ram (
        .i_clk   (i_clk),
        .i_we    (do_save),
        .i_waddr (r_ptr),
        .i_wdata (r_mac),
        .i_re    (do_read),
        .i_raddr (hit_idx),
        .o_rdata (ram_rdata)
    );

    assign o_rsp.valid   = r_v2;
    assign o_rsp.hit     = r_hit;
    assign o_rsp.mac_out = r_lookup_hit ? ram_rdata : '0;

`ifndef SYNTHESIS
    // a save never duplicates a key, so at most one slot can match
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $onehot0(match_vec))
        else $error("multiple table entries match one address");

    // a missed save lands in the slot under the pointer and marks it valid
    a_save_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_save |=> r_entry_valid[$past(r_ptr)] && (r_key[$past(r_ptr)] == $past(r_ip)))
        else $error("saved entry not written at replacement slot");

    // pointer only moves on a missed save
    a_ptr_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !do_save |=> $stable(r_ptr))
        else $error("replacement pointer moved without a save");
`endif

endmodule
